// ----- sv/swm_pkg.sv -----
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding window median filter
// Default sizes, the window size register format and the flag bundle that
// travels between neighboring cells of the sorted row.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int unsigned WindowMaxDef   = 64;
  localparam int unsigned SampleWidthDef = 32;
  localparam int unsigned CfgWidth       = 7;

  localparam logic [CfgWidth-1:0] WinSizeReset = 7'd3;

  // Comparison flags a cell hands to its neighbors.
  typedef struct packed {
    logic gt_new;  // cell value sorts after the incoming sample (or cell empty)
    logic ge_old;  // cell sits at or after the copy being dropped
  } swm_flag_t;

  // Window size actually used: zero acts as one, large values saturate.
  function automatic int unsigned swm_eff_size(logic [CfgWidth-1:0] ws,
                                               int unsigned wmax);
    int unsigned k;
    k = int'(ws);
    if (k == 0) begin
      k = 1;
    end
    if (k > wmax) begin
      k = wmax;
    end
    return k;
  endfunction

endpackage

// ----- sv/swm_cell.sv -----
// ----------------------------------------------------------------------------
// swm_cell: one slot of the sorted sample row
// Holds one sample, compares it with the incoming and the outgoing sample and
// takes its next value from itself, a neighbor or the incoming sample.
// ----------------------------------------------------------------------------
module swm_cell
  import swm_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic                    is_med_i,
  input  logic                    del_i,
  input  logic [SAMPLE_WIDTH-1:0] new_i,
  input  logic [SAMPLE_WIDTH-1:0] old_i,
  input  logic [SAMPLE_WIDTH-1:0] left_val_i,
  input  swm_flag_t               left_flag_i,
  input  logic [SAMPLE_WIDTH-1:0] right_val_i,
  input  logic                    right_gt_i,
  output logic [SAMPLE_WIDTH-1:0] val_o,
  output swm_flag_t               flag_o,
  output logic [SAMPLE_WIDTH-1:0] med_o
);

  logic [SAMPLE_WIDTH-1:0] val_q;
  logic [SAMPLE_WIDTH-1:0] val_d;
  logic [SAMPLE_WIDTH-1:0] ins_val;
  logic                    gt_new;
  logic                    ge_old;
  logic                    before_new;
  logic                    after_new;

  assign gt_new = !valid_i || ($signed(val_q) > $signed(new_i));
  assign ge_old = del_i && (!valid_i || ($signed(val_q) >= $signed(old_i)));

  assign flag_o = '{gt_new: gt_new, ge_old: ge_old};
  assign val_o  = val_q;

  // Slot lies before or after the final place of the incoming sample.
  assign before_new = ge_old ? !right_gt_i : !gt_new;
  assign after_new  = left_flag_i.ge_old ? gt_new : left_flag_i.gt_new;

  always_comb begin
    priority if (before_new) begin
      val_d = ge_old ? right_val_i : val_q;
    end else if (after_new) begin
      val_d = left_flag_i.ge_old ? val_q : left_val_i;
    end else begin
      val_d = new_i;
    end
  end

  // Value of this slot with the sample inserted but nothing dropped yet.
  always_comb begin
    priority if (left_flag_i.gt_new) begin
      ins_val = left_val_i;
    end else if (!gt_new) begin
      ins_val = val_q;
    end else begin
      ins_val = new_i;
    end
  end

  assign med_o = is_med_i ? ins_val : '0;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
    end
  end

endmodule

// ----- sv/swm_ring.sv -----
// ----------------------------------------------------------------------------
// swm_ring: arrival-order delay line
// Shifts every accepted sample one tap along and registers the sample that
// leaves the window on the next beat.
// ----------------------------------------------------------------------------
module swm_ring
  import swm_pkg::*;
#(
  parameter int unsigned WINDOW_MAX   = WindowMaxDef,
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef,
  localparam int unsigned CntW        = $clog2(WINDOW_MAX + 1),
  localparam int unsigned Taps        = (WINDOW_MAX > 2) ? WINDOW_MAX - 2 : 1
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [CntW-1:0]         k_i,
  input  logic [SAMPLE_WIDTH-1:0] sample_i,
  output logic [SAMPLE_WIDTH-1:0] oldest_o
);

  logic [SAMPLE_WIDTH-1:0] tap_q [Taps];
  logic [SAMPLE_WIDTH-1:0] oldest_q;
  logic [SAMPLE_WIDTH-1:0] oldest_d;
  logic [SAMPLE_WIDTH-1:0] tap_sel;

  // After this beat the oldest held sample sits k-2 taps in; pick it now.
  always_comb begin
    tap_sel = '0;
    for (int j = 0; j < Taps; j++) begin
      if (int'(k_i) == j + 3) begin
        tap_sel = tap_sel | tap_q[j];
      end
    end
    oldest_d = (int'(k_i) <= 2) ? sample_i : tap_sel;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= sample_i;
      for (int j = 1; j < Taps; j++) begin
        tap_q[j] <= tap_q[j-1];
      end
      oldest_q <= oldest_d;
    end
  end

  assign oldest_o = oldest_q;

endmodule

// ----- sv/sliding_window_median.sv -----
// ----------------------------------------------------------------------------
// sliding_window_median: running lower median over a window of samples
// Sorted row of cells: one insert per accepted beat, one drop per full beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/sample_i) takes one signed sample
//   per beat. Output channel (out_valid_o/out_ready_i/median_o) delivers the
//   lower median, the element of rank (k-1)/2 of the current window of k.
//   The first k-1 samples after reset or a window size write give no beat.
//   Result: the median of a full-window beat is registered at the accepting
//   edge and shows from an output register.
//   Throughput: one sample per clock while no result is stalled. Every cell
//   compares its sample with the incoming and the outgoing sample and moves in
//   the same cycle, so the whole row updates once per beat.
//   Stall: while a median waits unaccepted, in_ready_o drops; the result and
//   the window hold until out_ready_i returns.
//   Configuration: cfg_we_i writes the window size (zero acts as one, values
//   above WINDOW_MAX saturate) and empties the window. Write only while idle.
//   Reset: window size 3, window empty, no result pending. The sample stores
//   need no clearing; empty slots are tracked by the fill count.
// ----------------------------------------------------------------------------
module sliding_window_median
  import swm_pkg::*;
#(
  parameter int unsigned WINDOW_MAX   = WindowMaxDef,
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [CfgWidth-1:0]            cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] median_o
);

  localparam int unsigned IdxW = $clog2(WINDOW_MAX);
  localparam int unsigned CntW = $clog2(WINDOW_MAX + 1);

  localparam int unsigned KReset = swm_eff_size(WinSizeReset, WINDOW_MAX);

  // Window size and the indexes derived from it.
  logic [CntW-1:0] k_q, k_d;
  logic [IdxW-1:0] km1_q, km1_d;
  logic [IdxW-1:0] med_idx_q, med_idx_d;
  logic [IdxW-1:0] fill_q, fill_d;

  logic                    out_valid_q, out_valid_d;
  logic [SAMPLE_WIDTH-1:0] median_q;

  logic                    beat;
  logic                    full;
  logic [SAMPLE_WIDTH-1:0] oldest;
  logic [SAMPLE_WIDTH-1:0] med_sel;
  int unsigned             k_new;

  logic [SAMPLE_WIDTH-1:0] cell_val [WINDOW_MAX];
  logic [SAMPLE_WIDTH-1:0] cell_med [WINDOW_MAX];
  swm_flag_t               cell_flag [WINDOW_MAX];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign beat       = in_valid_i && in_ready_o;
  // Window holds k-1 samples: this beat completes it, so emit and drop oldest.
  assign full       = (fill_q == km1_q);

  // ---- configuration and fill count ----
  always_comb begin
    k_new     = swm_eff_size(cfg_wdata_i, WINDOW_MAX);
    k_d       = k_q;
    km1_d     = km1_q;
    med_idx_d = med_idx_q;
    fill_d    = fill_q;
    priority if (cfg_we_i) begin
      k_d       = CntW'(k_new);
      km1_d     = IdxW'(k_new - 1);
      med_idx_d = IdxW'((k_new - 1) >> 1);
      fill_d    = '0;
    end else if (beat && !full) begin
      fill_d = fill_q + 1'b1;
    end else begin
      fill_d = fill_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q       <= CntW'(KReset);
      km1_q     <= IdxW'(KReset - 1);
      med_idx_q <= IdxW'((KReset - 1) >> 1);
      fill_q    <= '0;
    end else begin
      k_q       <= k_d;
      km1_q     <= km1_d;
      med_idx_q <= med_idx_d;
      fill_q    <= fill_d;
    end
  end

  // ---- arrival order: yields the sample that leaves on a full beat ----
  swm_ring #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_ring (
    .clk_i   (clk_i),
    .en_i    (beat),
    .k_i     (k_q),
    .sample_i(sample_i),
    .oldest_o(oldest)
  );

  // ---- sorted row: cell 0 holds the smallest sample ----
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic [SAMPLE_WIDTH-1:0] left_val;
    swm_flag_t               left_flag;
    logic [SAMPLE_WIDTH-1:0] right_val;
    logic                    right_gt;

    if (i == 0) begin : g_first
      assign left_val  = '0;
      assign left_flag = '0;
    end else begin : g_mid_l
      assign left_val  = cell_val[i-1];
      assign left_flag = cell_flag[i-1];
    end

    // Past the last cell everything sorts after the incoming sample.
    if (i == WINDOW_MAX - 1) begin : g_last
      assign right_val = '0;
      assign right_gt  = 1'b1;
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
      assign right_gt  = cell_flag[i+1].gt_new;
    end

    swm_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .en_i       (beat),
      .valid_i    (IdxW'(i) < fill_q),
      .is_med_i   (IdxW'(i) == med_idx_q),
      .del_i      (full),
      .new_i      (sample_i),
      .old_i      (oldest),
      .left_val_i (left_val),
      .left_flag_i(left_flag),
      .right_val_i(right_val),
      .right_gt_i (right_gt),
      .val_o      (cell_val[i]),
      .flag_o     (cell_flag[i]),
      .med_o      (cell_med[i])
    );
  end

  // Only the median slot drives a nonzero value; merge the row.
  always_comb begin
    med_sel = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      med_sel = med_sel | cell_med[i];
    end
  end

  // ---- output register ----
  always_comb begin
    priority if (beat && full) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat && full) begin
      median_q <= med_sel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign median_o    = median_q;

`ifndef SYNTHESIS
  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= km1_q)
    else $error("fill count beyond window size");

  a_full_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && full |=> out_valid_o)
    else $error("full-window beat gave no result");

  a_fill_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && !full && !cfg_we_i |=> fill_q == IdxW'($past(fill_q) + 1'b1))
    else $error("fill count did not advance");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result stalled");
`endif

endmodule

// ----- dv/sliding_window_median_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_tb: self-checking bench of the running median filter
// Streams signed samples through the filter over a series of window sizes,
// predicts every lower median in a behavioral copy of the sorted window and
// checks each output beat in order, under random idling on both channels.
// ----------------------------------------------------------------------------
module sliding_window_median_tb;
  import swm_pkg::*;

  localparam int unsigned WinMax       = WindowMaxDef;
  localparam int unsigned SmpW         = SampleWidthDef;
  localparam int unsigned SettleCycles = 4;    // output register plus margin
  localparam int unsigned LongHold     = 250;  // one long receiver hold-off
  localparam int unsigned NumPhases    = 11;
  localparam int unsigned PausePhase   = 5;    // sender drains mid-phase here

  typedef logic signed [SmpW-1:0] smp_t;

  localparam smp_t SmpMax = {1'b0, {(SmpW-1){1'b1}}};
  localparam smp_t SmpMin = {1'b1, {(SmpW-1){1'b0}}};

  // Window sizes of the random phases: zero, one, even, odd, the built
  // maximum and a value past it that must saturate.
  logic [CfgWidth-1:0] phase_win [NumPhases] =
    '{7'd5, 7'd64, 7'd2, 7'd127, 7'd1, 7'd9, 7'd0, 7'd4, 7'd33, 7'd6, 7'd3};
  int unsigned phase_len [NumPhases] =
    '{140, 260, 110, 200, 90, 130, 70, 130, 160, 130, 140};

  // DUT ports
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgWidth-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  smp_t                sample_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  smp_t                median_o;

  // Stimulus and scoreboard state
  smp_t        pending_samples [$];  // samples waiting for the driver
  smp_t        median_due [$];       // predicted medians, oldest first
  int unsigned samples_queued = 0;
  int unsigned samples_taken  = 0;
  int unsigned medians_seen   = 0;
  int unsigned fail_count     = 0;
  logic        in_fire_q      = 1'b0;

  // Behavioral window: sorted copy, arrival order and configured size
  smp_t                sorted_win [$];
  smp_t                arrival_ring [WinMax];
  int unsigned         ring_slot  = 0;
  logic [CfgWidth-1:0] win_size_q = WinSizeReset;

  // Idle pattern state of both sides
  int unsigned tx_gap         = 0;
  int unsigned tx_calm        = 0;
  int unsigned rx_stall       = 0;
  int unsigned rx_calm        = 0;
  logic        long_hold_done = 1'b0;

  sliding_window_median #(
    .WINDOW_MAX  (WinMax),
    .SAMPLE_WIDTH(SmpW)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .median_o   (median_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Window length in use: zero acts as one, oversize clamps to the maximum.
  function automatic int unsigned window_len(input logic [CfgWidth-1:0] ws);
    if (ws == '0) begin
      return 1;
    end
    if (ws > WinMax) begin
      return WinMax;
    end
    return ws;
  endfunction

  // Advance the behavioral window by one sample. Return 1 with the lower
  // median when the window is full, then drop one copy of the oldest sample.
  function automatic bit next_median(input smp_t smp, output smp_t med);
    int unsigned k;
    int unsigned pos;
    smp_t        oldest;
    k   = window_len(win_size_q);
    med = '0;
    if (ring_slot >= k) begin
      ring_slot = 0;
    end
    if (sorted_win.size() >= k) begin
      sorted_win.delete();
    end
    arrival_ring[ring_slot] = smp;
    ring_slot = (ring_slot + 1 == k) ? 0 : ring_slot + 1;
    // Insert after any equal values so duplicates stay in arrival order.
    pos = sorted_win.size();
    while (pos > 0 && sorted_win[pos-1] > smp) begin
      pos--;
    end
    sorted_win.insert(pos, smp);
    if (sorted_win.size() < k) begin
      return 1'b0;
    end
    med    = sorted_win[(k-1)/2];
    oldest = arrival_ring[ring_slot];
    for (pos = 0; pos < sorted_win.size(); pos++) begin
      if (sorted_win[pos] == oldest) begin
        sorted_win.delete(pos);
        break;
      end
    end
    return 1'b1;
  endfunction

  // Idle length: mostly none or short, a few long, and now and then a calm
  // stretch with no idling at all.
  function automatic int unsigned next_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(30, 100);
      return 0;
    end
    if (r < 55) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Random sample: many from narrow ranges so that duplicates are common,
  // some extremes, the rest over the full range.
  function automatic smp_t rand_sample();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      return smp_t'(int'($urandom_range(0, 8)) - 4);
    end
    if (pick == 3) begin
      return smp_t'(int'($urandom_range(0, 1000)) - 500);
    end
    if (pick == 4) begin
      case ($urandom_range(0, 3))
        0:       return SmpMax;
        1:       return SmpMin;
        2:       return '0;
        default: return '1;
      endcase
    end
    return smp_t'($urandom);
  endfunction

  // Driver: present the next pending sample at the falling edge, hold valid
  // and payload until the beat is taken, then insert a random gap.
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_fire_q)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        sample_i   <= pending_samples.pop_front();
        in_valid_i <= 1'b1;
        tx_gap     = next_gap(tx_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off while the sender still
  // has plenty queued, so that the filter backs up and drops in_ready_o.
  always @(negedge clk_i) begin
    int unsigned gap;
    if (rx_stall > 0) begin
      rx_stall--;
      out_ready_i <= 1'b0;
    end else if (!long_hold_done && medians_seen >= 100 &&
                 pending_samples.size() > 20) begin
      long_hold_done = 1'b1;
      rx_stall       = LongHold - 1;
      out_ready_i    <= 1'b0;
    end else begin
      gap = next_gap(rx_calm);
      if (gap == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        rx_stall    = gap - 1;
        out_ready_i <= 1'b0;
      end
    end
  end

  // Monitor: at each rising edge track window writes, check an output beat
  // against the oldest predicted median, then predict from an input beat.
  // Check before predicting so a beat taken at this edge cannot mask a
  // spurious output.
  always @(posedge clk_i) begin
    smp_t want;
    if (rst_ni) begin
      in_fire_q <= in_valid_i && in_ready_o;
      if (cfg_we_i) begin
        win_size_q = cfg_wdata_i;
        sorted_win.delete();
        ring_slot  = 0;
      end
      if (out_valid_o && out_ready_i) begin
        if (median_due.size() == 0) begin
          $display("%0t: unexpected median beat, expected none, actual %0d",
                   $time, median_o);
          fail_count++;
        end else begin
          want = median_due.pop_front();
          if (median_o !== want) begin
            $display("%0t: median mismatch, expected %0d, actual %0d",
                     $time, want, median_o);
            fail_count++;
          end
        end
        medians_seen <= medians_seen + 1;
      end
      if (in_valid_i && in_ready_o) begin
        samples_taken <= samples_taken + 1;
        if (next_median(sample_i, want)) begin
          median_due = {median_due, want};
        end
      end
    end
  end

  task automatic queue_sample(input smp_t smp);
    pending_samples = {pending_samples, smp};
    samples_queued++;
  endtask

  // Hold until every queued sample is taken and every median has come, then
  // let samples that give no median finish inside the filter.
  task automatic wait_idle();
    while (samples_taken != samples_queued || median_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Window size writes happen only once the filter is idle.
  task automatic write_window(input logic [CfgWidth-1:0] ws);
    wait_idle();
    cfg_wdata_i <= ws;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int unsigned p;
    int unsigned n;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset window of three: extremes, sign boundaries, a run of equal values.
    queue_sample(SmpMax);
    queue_sample(SmpMin);
    queue_sample('0);
    queue_sample('1);
    queue_sample(smp_t'(1));
    queue_sample(smp_t'(5));
    queue_sample(smp_t'(5));
    queue_sample(smp_t'(5));
    queue_sample(smp_t'(-5));

    // Size zero acts as one; the write also flushes the partial window.
    write_window(7'd0);
    queue_sample(SmpMin);
    queue_sample(SmpMax);
    queue_sample(smp_t'(42));

    // Even window, duplicates on both signs; leave one sample held.
    write_window(7'd2);
    queue_sample(smp_t'(3));
    queue_sample(smp_t'(3));
    queue_sample(smp_t'(-3));
    queue_sample(smp_t'(-3));
    queue_sample(smp_t'(7));

    // Rewrite drops the held sample; duplicated extremes.
    write_window(7'd3);
    queue_sample(SmpMax);
    queue_sample(SmpMax);
    queue_sample(SmpMin);
    queue_sample(SmpMin);

    // Random phases, one window size each.
    for (p = 0; p < NumPhases; p++) begin
      write_window(phase_win[p]);
      for (n = 0; n < phase_len[p]; n++) begin
        if (p == PausePhase && n == phase_len[p] / 2) begin
          wait_idle();
        end
        queue_sample(rand_sample());
      end
    end

    wait_idle();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && median_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
